// ===== hdl/tcw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int COPY_N  = COLUMNS * (ROWS - 1);

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int OROW_W  = 5;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0000;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCROLL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic take;       // accept the item at the input
        logic cnt_rst;    // restart the sweep counter
        logic clr_step;   // write one blank cell at the counter
        logic scr_step;   // one scroll step at the counter
        logic out_load;   // load the result word
    } t_dp_cmd;

    typedef struct packed {
        logic scroll;     // the put item at the input runs past the last row
        logic cnt_last;   // the counter is at the last cell
        logic out_free;   // the result register can take a word
    } t_dp_stat;

endpackage

// ===== hdl/tcw_ctrl.sv =====
// Controller state machine: sequences item handling, clear sweeps and scroll sweeps.
`timescale 1ns / 1ps
module tcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tcw_pkg::t_kind    i_kind,
    input  tcw_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output tcw_pkg::t_dp_cmd  o_cmd
);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tcw_pkg::ST_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.cnt_rst = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_kind == tcw_pkg::KIND_CLEAR) begin
                        n_state = tcw_pkg::ST_CLEAR;
                    end else if (i_kind == tcw_pkg::KIND_PUT && i_stat.scroll) begin
                        n_state = tcw_pkg::ST_SCROLL;
                    end else begin
                        n_state = tcw_pkg::ST_FINISH;
                    end
                end
            end
            tcw_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = tcw_pkg::ST_FINISH;
                end
            end
            tcw_pkg::ST_SCROLL: begin
                o_cmd.scr_step = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = tcw_pkg::ST_FINISH;
                end
            end
            tcw_pkg::ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/tcw_datapath.sv =====
// Datapath: frame store memory, cursor, sweep counter and result register.
`timescale 1ns / 1ps
module tcw_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcw_pkg::t_dp_cmd             i_cmd,
    input  tcw_pkg::t_kind               i_kind,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_color,
    input  logic [tcw_pkg::IDX_W-1:0]    i_cell_index,
    input  logic                         i_out_ready,
    output tcw_pkg::t_dp_stat            o_stat,
    output logic                         o_out_valid,
    output logic [tcw_pkg::CELL_W-1:0]   o_cell_value,
    output logic [tcw_pkg::COL_W-1:0]    o_cursor_column,
    output logic [tcw_pkg::OROW_W-1:0]   o_cursor_row
);

    localparam int AW = tcw_pkg::ADDR_W;

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];

    logic [AW-1:0]                r_cnt;
    logic [tcw_pkg::COL_W-1:0]    r_col;
    logic [tcw_pkg::ROW_W-1:0]    r_row;
    logic [tcw_pkg::CELL_W-1:0]   r_rd_data;
    logic                         r_is_read;
    logic                         r_cp_valid;
    logic                         r_cp_zero;
    logic [AW-1:0]                r_cp_addr;
    logic                         r_out_valid;
    logic [tcw_pkg::CELL_W-1:0]   r_out_value;
    logic [tcw_pkg::COL_W-1:0]    r_out_col;
    logic [tcw_pkg::OROW_W-1:0]   r_out_row;

    logic                         is_put;
    logic                         is_newline;
    logic                         wrap;
    logic                         last_row;
    logic                         read_ok;
    logic                         in_copy;
    logic [AW-1:0]                cur_addr;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [tcw_pkg::CELL_W-1:0]   wr_data;

    assign is_put     = (i_kind == tcw_pkg::KIND_PUT);
    assign is_newline = (i_char_code == tcw_pkg::NEWLINE_CODE);
    assign wrap       = is_newline || (r_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign last_row   = (r_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign read_ok    = (i_kind == tcw_pkg::KIND_READ) && (int'(i_cell_index) < tcw_pkg::CELLS);
    assign in_copy    = (int'(r_cnt) < tcw_pkg::COPY_N);
    assign cur_addr   = AW'(r_row) * AW'(tcw_pkg::COLUMNS) + AW'(r_col);

    assign o_stat.scroll   = is_put && wrap && last_row;
    assign o_stat.cnt_last = (r_cnt == AW'(tcw_pkg::CELLS - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Read port: item reads at accept, shifted rows during a scroll.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_cnt + AW'(tcw_pkg::COLUMNS);
        if (i_cmd.take && read_ok) begin
            rd_en   = 1'b1;
            rd_addr = AW'(i_cell_index);
        end else if (i_cmd.scr_step && in_copy) begin
            rd_en = 1'b1;
        end
    end

    // Write port: pending scroll write first, then clear sweep, then character put.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = {i_color, i_char_code};
        priority if (r_cp_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_cp_addr;
            wr_data = r_cp_zero ? tcw_pkg::BLANK_CELL : r_rd_data;
        end else if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt;
            wr_data = tcw_pkg::BLANK_CELL;
        end else if (i_cmd.take && is_put && !is_newline) begin
            wr_en = 1'b1;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Scroll writes follow their reads in the next cycle.
    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_cnt;
        r_cp_zero <= !in_copy;
        if (i_cmd.take) begin
            r_is_read <= read_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            r_cp_valid <= i_cmd.scr_step;
            if (i_cmd.cnt_rst) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step || i_cmd.scr_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.take) begin
                if (i_kind == tcw_pkg::KIND_CLEAR) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (is_put) begin
                    if (wrap) begin
                        r_col <= '0;
                        // hold the bottom row when the store scrolls
                        if (!last_row) begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= r_is_read ? r_rd_data : tcw_pkg::BLANK_CELL;
            r_out_col   <= r_col;
            r_out_row   <= tcw_pkg::OROW_W'(r_row);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_value    = r_out_value;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;

endmodule

// ===== hdl/text_console_writer.sv =====
// Top level of the text console writer: stream ports, controller and datapath.
// Put, read and ignored items: the finish state loads the result word once the result
// register is free, and the next item is accepted only back in idle. Clear and scroll: the
// sweep counter walks all 2000 cells one per cycle first; input stays stalled meanwhile.
// The result register lets the next item be accepted while a word waits at the output.
// Reset: synchronous, active low; then a clearing pass over all 2000 cells, input not ready.
`timescale 1ns / 1ps
module text_console_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // char_code[7:0], color[15:8], cell_index[26:16]
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // cell_value[15:0], cursor_column[22:16],
                                          // cursor_row[27:23]
);

    tcw_pkg::t_dp_cmd  cmd;
    tcw_pkg::t_dp_stat stat;
    tcw_pkg::t_kind    kind;

    logic [tcw_pkg::CELL_W-1:0] cell_value;
    logic [tcw_pkg::COL_W-1:0]  cursor_column;
    logic [tcw_pkg::OROW_W-1:0] cursor_row;

    assign kind = tcw_pkg::t_kind'(i_s_axis_tuser);

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_kind     (kind),
        .i_stat     (stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (kind),
        .i_char_code     (i_s_axis_tdata[7:0]),
        .i_color         (i_s_axis_tdata[15:8]),
        .i_cell_index    (i_s_axis_tdata[26:16]),
        .i_out_ready     (i_m_axis_tready),
        .o_stat          (stat),
        .o_out_valid     (o_m_axis_tvalid),
        .o_cell_value    (cell_value),
        .o_cursor_column (cursor_column),
        .o_cursor_row    (cursor_row)
    );

    assign o_m_axis_tdata = {4'b0, cursor_row, cursor_column, cell_value};

endmodule

// ===== tb/console_checker.sv =====
// Result checker for the text console writer: shadow screen, cursor and expected result words.
`timescale 1ns / 1ps
module console_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // char_code[7:0], color[15:8], cell_index[26:16]
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,   // cell_value[15:0], cursor_column[22:16],
                                          // cursor_row[27:23]
    output int          o_fail_count,
    output int          o_words_pending
);

    typedef struct packed {
        logic [tcw_pkg::CELL_W-1:0] value;
        logic [tcw_pkg::COL_W-1:0]  col;
        logic [tcw_pkg::OROW_W-1:0] row;
    } t_screen_word;

    logic [tcw_pkg::CELL_W-1:0] shadow_cells [tcw_pkg::CELLS];
    int                         cur_col;
    int                         cur_row;
    t_screen_word               screen_words [$];
    t_screen_word               want_word;
    t_screen_word               got_word;
    int                         fail_count   = 0;
    int                         words_queued = 0;
    int                         shown        = 0;

    assign o_fail_count    = fail_count;
    assign o_words_pending = words_queued;

    task automatic blank_shadow(input int first);
        for (int i = first; i < tcw_pkg::CELLS; i++) shadow_cells[i] = tcw_pkg::BLANK_CELL;
    endtask

    task automatic predict_console_item(input tcw_pkg::t_kind kind,
                                        input logic [tcw_pkg::CHAR_W-1:0] ch,
                                        input logic [7:0] attr,
                                        input logic [tcw_pkg::IDX_W-1:0] idx,
                                        output t_screen_word word);
        logic [tcw_pkg::CELL_W-1:0] value;
        int                         addr;
        value = tcw_pkg::BLANK_CELL;
        unique case (kind)
            tcw_pkg::KIND_PUT: begin
                if (ch == tcw_pkg::NEWLINE_CODE) begin
                    cur_col = 0;
                    cur_row++;
                end else begin
                    addr = cur_row * tcw_pkg::COLUMNS + cur_col;
                    if (addr < tcw_pkg::CELLS) begin
                        shadow_cells[addr] = {attr, ch};
                        cur_col++;
                    end
                end
                if (cur_col >= tcw_pkg::COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // scroll up one row and blank the bottom row
                if (cur_row >= tcw_pkg::ROWS) begin
                    for (int i = 0; i < tcw_pkg::COPY_N; i++) begin
                        shadow_cells[i] = shadow_cells[i + tcw_pkg::COLUMNS];
                    end
                    blank_shadow(tcw_pkg::COPY_N);
                    cur_row = tcw_pkg::ROWS - 1;
                    cur_col = 0;
                end
            end
            tcw_pkg::KIND_CLEAR: begin
                blank_shadow(0);
                cur_col = 0;
                cur_row = 0;
            end
            tcw_pkg::KIND_READ: begin
                if (idx < tcw_pkg::CELLS) value = shadow_cells[idx];
            end
            default: ;
        endcase
        word.value = value;
        word.col   = tcw_pkg::COL_W'(cur_col);
        word.row   = tcw_pkg::OROW_W'(cur_row);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blank_shadow(0);
            cur_col = 0;
            cur_row = 0;
            screen_words.delete();
            words_queued <= 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_console_item(tcw_pkg::t_kind'(i_s_axis_tuser), i_s_axis_tdata[7:0],
                                     i_s_axis_tdata[15:8], i_s_axis_tdata[26:16], want_word);
                screen_words.push_back(want_word);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_word.value = i_m_axis_tdata[15:0];
                got_word.col   = i_m_axis_tdata[22:16];
                got_word.row   = i_m_axis_tdata[27:23];
                if (screen_words.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (shown < 10) begin
                        $display("unexpected word: value %h col %0d row %0d",
                                 got_word.value, got_word.col, got_word.row);
                        shown++;
                    end
                end else begin
                    want_word = screen_words.pop_front();
                    if (got_word.value != want_word.value || got_word.col != want_word.col ||
                        got_word.row != want_word.row) begin
                        fail_count <= fail_count + 1;
                        if (shown < 10) begin
                            $display(
                                "mismatch: expected %h col %0d row %0d, got %h col %0d row %0d",
                                want_word.value, want_word.col, want_word.row,
                                got_word.value, got_word.col, got_word.row);
                            shown++;
                        end
                    end
                end
            end
            words_queued <= screen_words.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the text console writer bench: clock, reset, item stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;

    localparam int RANDOM_ITEMS = 550;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 2100;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // char_code[7:0], color[15:8], cell_index[26:16]
    logic [1:0]  s_tuser  = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // cell_value[15:0], cursor_column[22:16], cursor_row[27:23]
    int          fail_count;
    int          words_pending;
    int          send_idle_pct = 20;
    int          recv_idle_pct = 74;

    text_console_writer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    console_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // end the run after too many cycles without any word moving
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // hold the word until accepted; leave tvalid high for a back-to-back follower
    task automatic send_item(input tcw_pkg::t_kind kind,
                             input logic [tcw_pkg::CHAR_W-1:0] ch,
                             input logic [7:0] color,
                             input logic [tcw_pkg::IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, idx, color, ch};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
    endtask

    initial begin
        int                         pick;
        int                         newline_pct;
        tcw_pkg::t_kind             kind;
        logic [tcw_pkg::CHAR_W-1:0] ch;
        logic [7:0]                 color;
        logic [tcw_pkg::IDX_W-1:0]  idx;

        newline_pct = 2;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0);
        send_item(tcw_pkg::KIND_PUT, 8'h41, 8'h00, 11'd0);
        send_item(tcw_pkg::KIND_PUT, 8'h00, 8'hFF, 11'h7FF);
        send_item(tcw_pkg::KIND_PUT, 8'hFF, 8'hFF, 11'd0);
        send_item(tcw_pkg::KIND_PUT, 8'hFF, 8'h00, 11'd0);
        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0);
        send_item(tcw_pkg::KIND_READ, 8'hFF, 8'hFF, 11'd1);
        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd3);
        send_item(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, 8'hA5, 11'd0);
        send_item(tcw_pkg::KIND_PUT, 8'h55, 8'hAA, 11'd0);
        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'(tcw_pkg::COLUMNS));
        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'(tcw_pkg::CELLS - 1));
        // out-of-range reads return a blank word
        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'(tcw_pkg::CELLS));
        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'h7FF);
        // unknown kind leaves the screen and cursor alone
        send_item(tcw_pkg::KIND_NONE, 8'hFF, 8'hFF, 11'h7FF);
        send_item(tcw_pkg::KIND_NONE, tcw_pkg::NEWLINE_CODE, 8'h3C, 11'd5);
        send_item(tcw_pkg::KIND_CLEAR, 8'h00, 8'h00, 11'd0);
        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0);
        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'(tcw_pkg::COLUMNS));
        send_item(tcw_pkg::KIND_PUT, 8'h0B, 8'h5A, 11'd0);
        send_item(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                send_idle_pct = 74;
                recv_idle_pct = 20;
            end
            if (i == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // switch at random between long text lines and newline-heavy stretches that scroll
            if (i % 40 == 0) newline_pct = $urandom_range(0, 1) ? 60 : 2;
            ch    = tcw_pkg::CHAR_W'($urandom_range(0, 255));
            color = 8'($urandom_range(0, 255));
            idx   = tcw_pkg::IDX_W'($urandom_range(0, 2047));
            pick  = int'($urandom_range(0, 199));
            if (pick < 1) begin
                kind = tcw_pkg::KIND_CLEAR;
            end else if (pick < 8) begin
                kind = tcw_pkg::KIND_NONE;
            end else if (pick < 60) begin
                kind = tcw_pkg::KIND_READ;
                case ($urandom_range(0, 3))
                    0: idx = tcw_pkg::IDX_W'($urandom_range(0, 2047));
                    1: idx = tcw_pkg::IDX_W'($urandom_range(0, tcw_pkg::CELLS - 1));
                    2: idx = tcw_pkg::IDX_W'($urandom_range(tcw_pkg::CELLS - tcw_pkg::COLUMNS,
                                                            tcw_pkg::CELLS - 1));
                    default: idx = tcw_pkg::IDX_W'($urandom_range(0, 2 * tcw_pkg::COLUMNS - 1));
                endcase
            end else begin
                kind = tcw_pkg::KIND_PUT;
                if ($urandom_range(0, 99) < newline_pct) ch = tcw_pkg::NEWLINE_CODE;
            end
            send_item(kind, ch, color, idx);
        end
        s_tvalid <= 1'b0;

        do @(posedge clk); while (words_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && words_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
